/* rtl/ilf_pkg.sv */
`default_nettype none
package ilf_pkg;

  // result status, lowest bit first: updated, singular
  typedef struct packed {
    logic singular;
    logic updated;
  } flags_t;

  localparam int LINE_W = 32;
  localparam logic signed [LINE_W-1:0] LINE_MAX = 32'sh7fff_ffff;
  localparam logic signed [LINE_W-1:0] LINE_MIN = -32'sh7fff_ffff - 32'sd1;

endpackage
`default_nettype wire

/* rtl/ilf_front.sv */
`default_nettype none
module ilf_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  input  wire logic [SAMPLE_BITS-1:0]   x_in,
  input  wire logic [SAMPLE_BITS-1:0]   y_in,
  input  wire logic                     last_in,
  output logic                          q_valid,
  input  wire logic                     q_ready,
  output logic [2*SAMPLE_BITS:0]        q_data   // {last, y, x}
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int W     = 2 * SAMPLE_BITS + 1;

  logic [W-1:0]     mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   fill;
  logic             push;
  logic             pop;

  assign s_tready = (fill != (PTR_W+1)'(DEPTH));
  assign q_valid  = (fill != '0);
  assign push     = s_tvalid && s_tready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= {last_in, y_in, x_in};
    end
  end

  assign q_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      case ({push, pop})
        2'b10:   fill <= fill + (PTR_W+1)'(1);
        2'b01:   fill <= fill - (PTR_W+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/ilf_mul.sv */
`default_nettype none
// shift-add multiplier, one bit of b per cycle, exact signed product
module ilf_mul #(
  parameter int A_W = 81,
  parameter int B_W = 48
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic signed [A_W-1:0]   a,
  input  wire logic signed [B_W-1:0]   b,
  output logic                         done,
  output logic signed [A_W+B_W-1:0]    p
);

  localparam int P_W   = A_W + B_W;
  localparam int CNT_W = $clog2(B_W + 1);

  logic [P_W-1:0]   acc;
  logic [P_W-1:0]   am;
  logic [B_W-1:0]   bm;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             neg;
  logic [A_W-1:0]   a_mag;
  logic [B_W-1:0]   b_mag;

  assign a_mag = a[A_W-1] ? A_W'(-a) : A_W'(a);
  assign b_mag = b[B_W-1] ? B_W'(-b) : B_W'(b);

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      am  <= P_W'(a_mag);
      bm  <= b_mag;
      neg <= a[A_W-1] ^ b[B_W-1];
    end else if (busy) begin
      if (bm[0]) acc <= acc + am;
      am <= am << 1;
      bm <= bm >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(B_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign p = neg ? -signed'(acc) : signed'(acc);

endmodule
`default_nettype wire

/* rtl/ilf_div.sv */
`default_nettype none
// restoring divider, one quotient bit per cycle; rounds to nearest, ties away from zero
module ilf_div #(
  parameter int N_W = 129,
  parameter int D_W = 66
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic signed [N_W-1:0]   n,
  input  wire logic signed [D_W-1:0]   d,
  output logic                         done,
  output logic signed [N_W+1:0]        q
);

  localparam int CNT_W = $clog2(N_W + 2);

  logic [N_W:0]     num;
  logic [D_W:0]     den;
  logic [D_W:0]     rem;
  logic [N_W:0]     quo;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             neg;
  logic [N_W-1:0]   n_mag;
  logic [D_W-1:0]   d_mag;
  logic [D_W+1:0]   r_sh;
  logic             fits;
  logic signed [N_W+1:0] q_pos;

  assign n_mag = n[N_W-1] ? N_W'(-n) : N_W'(n);
  assign d_mag = d[D_W-1] ? D_W'(-d) : D_W'(d);
  assign r_sh  = {rem, num[N_W]};
  assign fits  = (r_sh >= (D_W+2)'(den));

  always_ff @(posedge clk) begin
    if (start) begin
      // (2|n| + |d|) / (2|d|)
      num <= {n_mag, 1'b0} + (N_W+1)'(d_mag);
      den <= {d_mag, 1'b0};
      rem <= '0;
      quo <= '0;
      neg <= n[N_W-1] ^ d[D_W-1];
    end else if (busy) begin
      num <= num << 1;
      if (fits) begin
        rem <= (D_W+1)'(r_sh - (D_W+2)'(den));
        quo <= {quo[N_W-1:0], 1'b1};
      end else begin
        rem <= (D_W+1)'(r_sh);
        quo <= {quo[N_W-1:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(N_W + 1);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign q_pos = signed'({1'b0, quo});
  assign q     = neg ? -q_pos : q_pos;

endmodule
`default_nettype wire

/* rtl/ilf_back.sv */
`default_nettype none
module ilf_back #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16,
  parameter int COUNT_BITS  = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    q_valid,
  output logic                         q_ready,
  input  wire logic [2*SAMPLE_BITS:0]  q_data,
  output logic                         m_valid,
  input  wire logic                    m_ready,
  output logic signed [31:0]           slope_out,
  output logic signed [31:0]           offset_out,
  output ilf_pkg::flags_t              flags_out
);

  localparam int SB     = SAMPLE_BITS;
  localparam int XX_W   = 2 * SB - 1 + COUNT_BITS;
  localparam int X_W    = SB + COUNT_BITS + 1;
  localparam int N_W    = COUNT_BITS + 1;
  localparam int XY_W   = 2 * SB + COUNT_BITS;
  localparam int RHS_W  = XX_W + 34;
  localparam int B_W    = XX_W + 1;
  localparam int PROD_W = RHS_W + B_W;
  localparam int NUM_W  = PROD_W;
  localparam int DET_W  = 2 * SB + 2 * COUNT_BITS + 2;
  localparam int Q_W    = NUM_W + 2;
  localparam int S_W    = Q_W + 1;
  localparam int LW     = ilf_pkg::LINE_W;

  typedef enum logic [2:0] {
    S_IDLE, S_ACC, S_TOT, S_MUL_GO, S_MUL_WAIT, S_DIV_GO, S_DIV_WAIT, S_OUT
  } state_t;

  typedef enum logic [3:0] {
    K_BXX_S, K_BX_C, K_BX_S, K_BN_C, K_TXX_TN, K_TX_TX,
    K_TN_R0, K_TX_R1, K_TXX_R1, K_TX_R0
  } step_t;

  state_t state;
  step_t  k;
  logic   div_sel;

  logic signed [SB-1:0]     x_r, y_r;
  logic                     last_r;
  logic [XX_W-1:0]          batch_xx, total_xx;
  logic signed [X_W-1:0]    batch_x, total_x, batch_y;
  logic [N_W-1:0]           batch_count, total_count;
  logic signed [XY_W-1:0]   batch_xy;
  logic signed [LW-1:0]     slope_r, offset_r;
  logic signed [PROD_W-1:0] t_r;
  logic signed [RHS_W-1:0]  rhs0, rhs1;
  logic signed [DET_W-1:0]  det_r;
  logic signed [NUM_W-1:0]  n0, n1;
  ilf_pkg::flags_t          flags_r;

  logic signed [2*SB-1:0]   xx, xy;
  logic signed [RHS_W-1:0]  mul_a;
  logic signed [B_W-1:0]    mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic                     mul_done;
  logic signed [PROD_W-1:0] diff;
  logic signed [DET_W-1:0]  det_c;
  logic signed [Q_W-1:0]    div_q;
  logic                     div_done;
  logic signed [S_W-1:0]    line_sum;
  logic signed [LW-1:0]     line_sat;

  assign q_ready = (state == S_IDLE);
  assign xx      = x_r * x_r;
  assign xy      = x_r * y_r;
  assign diff    = t_r - mul_p;
  assign det_c   = DET_W'(diff);

  always_comb begin
    case (k)
      K_BXX_S:  begin mul_a = RHS_W'(slope_r);     mul_b = B_W'(batch_xx);    end
      K_BX_C:   begin mul_a = RHS_W'(offset_r);    mul_b = B_W'(batch_x);     end
      K_BX_S:   begin mul_a = RHS_W'(slope_r);     mul_b = B_W'(batch_x);     end
      K_BN_C:   begin mul_a = RHS_W'(offset_r);    mul_b = B_W'(batch_count); end
      K_TXX_TN: begin mul_a = RHS_W'(total_count); mul_b = B_W'(total_xx);    end
      K_TX_TX:  begin mul_a = RHS_W'(total_x);     mul_b = B_W'(total_x);     end
      K_TN_R0:  begin mul_a = rhs0;                mul_b = B_W'(total_count); end
      K_TX_R1:  begin mul_a = rhs1;                mul_b = B_W'(total_x);     end
      K_TXX_R1: begin mul_a = rhs1;                mul_b = B_W'(total_xx);    end
      K_TX_R0:  begin mul_a = rhs0;                mul_b = B_W'(total_x);     end
      default:  begin mul_a = '0;                  mul_b = '0;                end
    endcase
  end

  ilf_mul #(.A_W(RHS_W), .B_W(B_W)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_MUL_GO),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  ilf_div #(.N_W(NUM_W), .D_W(DET_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_DIV_GO),
    .n     (div_sel ? n1 : n0),
    .d     (det_r),
    .done  (div_done),
    .q     (div_q)
  );

  always_comb begin
    line_sum = S_W'(div_sel ? offset_r : slope_r) + S_W'(div_q);
    if (line_sum > S_W'(ilf_pkg::LINE_MAX))      line_sat = ilf_pkg::LINE_MAX;
    else if (line_sum < S_W'(ilf_pkg::LINE_MIN)) line_sat = ilf_pkg::LINE_MIN;
    else                                         line_sat = LW'(line_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      k           <= K_BXX_S;
      div_sel     <= 1'b0;
      m_valid     <= 1'b0;
      flags_r     <= '0;
      batch_xx    <= '0;
      batch_x     <= '0;
      batch_count <= '0;
      batch_xy    <= '0;
      batch_y     <= '0;
      total_xx    <= '0;
      total_x     <= '0;
      total_count <= '0;
      slope_r     <= '0;
      offset_r    <= '0;
    end else begin
      if (m_valid && m_ready) m_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            x_r     <= signed'(q_data[SB-1:0]);
            y_r     <= signed'(q_data[2*SB-1:SB]);
            last_r  <= q_data[2*SB];
            flags_r <= '0;
            state   <= S_ACC;
          end
        end
        S_ACC: begin
          batch_xx    <= batch_xx + XX_W'(xx);
          batch_x     <= batch_x + X_W'(x_r);
          batch_count <= batch_count + N_W'(1);
          batch_xy    <= batch_xy + XY_W'(xy);
          batch_y     <= batch_y + X_W'(y_r);
          state       <= last_r ? S_TOT : S_OUT;
        end
        S_TOT: begin
          total_xx    <= total_xx + batch_xx;
          total_x     <= total_x + batch_x;
          total_count <= total_count + batch_count;
          k           <= K_BXX_S;
          state       <= S_MUL_GO;
        end
        S_MUL_GO: begin
          state <= S_MUL_WAIT;
        end
        S_MUL_WAIT: begin
          if (mul_done) begin
            k     <= step_t'(k + 4'd1);
            state <= S_MUL_GO;
            case (k)
              K_BX_C:
                rhs0 <= (RHS_W'(batch_xy) <<< FRAC_BITS) - RHS_W'(t_r) - RHS_W'(mul_p);
              K_BN_C:
                rhs1 <= (RHS_W'(batch_y) <<< FRAC_BITS) - RHS_W'(t_r) - RHS_W'(mul_p);
              K_TX_TX: begin
                det_r <= det_c;
                if (det_c == '0) begin
                  flags_r.singular <= 1'b1;
                  state            <= S_OUT;
                end
              end
              K_TX_R1: n0 <= NUM_W'(diff);
              K_TX_R0: begin
                n1      <= NUM_W'(diff);
                div_sel <= 1'b0;
                state   <= S_DIV_GO;
              end
              default: t_r <= mul_p;
            endcase
          end
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            if (!div_sel) begin
              slope_r <= line_sat;
              div_sel <= 1'b1;
              state   <= S_DIV_GO;
            end else begin
              offset_r        <= line_sat;
              flags_r.updated <= 1'b1;
              state           <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (!m_valid || m_ready) begin
            slope_out  <= slope_r;
            offset_out <= offset_r;
            flags_out  <= flags_r;
            m_valid    <= 1'b1;
            if (last_r) begin
              batch_xx    <= '0;
              batch_x     <= '0;
              batch_count <= '0;
              batch_xy    <= '0;
              batch_y     <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/incremental_line_fit.sv */
// Mid-batch sample: the request is taken in S_IDLE, summed in S_ACC and its result registered in S_OUT.
// Batch end: 10 shift-add multiplies and two restoring divides; a zero determinant ends the
// batch after the determinant multiply, with no divides.
// The back end takes a new request only once it is idle again; the 4-entry input queue and
// output register let both sides stall independently.
// Synchronous active-high reset clears sums, totals, line, queue and output valid.
`default_nettype none
module incremental_line_fit #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16,
  parameter int COUNT_BITS  = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // x_sample, y_sample, zero pad
  input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
  input  wire logic                               s_tlast,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // slope, offset
  output logic [63:0]                             m_tdata,
  // updated, singular
  output logic [1:0]                              m_tuser
);

  logic                    q_valid;
  logic                    q_ready;
  logic [2*SAMPLE_BITS:0]  q_data;
  logic signed [31:0]      slope;
  logic signed [31:0]      offset;
  ilf_pkg::flags_t         flags;

  ilf_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .x_in     (s_tdata[SAMPLE_BITS-1:0]),
    .y_in     (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .last_in  (s_tlast),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data)
  );

  ilf_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_data     (q_data),
    .m_valid    (m_tvalid),
    .m_ready    (m_tready),
    .slope_out  (slope),
    .offset_out (offset),
    .flags_out  (flags)
  );

  assign m_tdata = {offset, slope};
  assign m_tuser = flags;

endmodule
`default_nettype wire

/* rtl/ilf_checker.sv */
`default_nettype none
module ilf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [63:0] m_tdata,
  input wire logic [1:0]  m_tuser
);

  // a batch end either solves or is singular, never both
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("updated and singular both set");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_rst_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // queue is empty after reset, so a request can be taken at once
  a_rst_in: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready after reset");

endmodule

bind incremental_line_fit ilf_checker u_ilf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire

/* tb/sv/tb_incremental_line_fit.sv */
`default_nettype none
module tb_incremental_line_fit;

  localparam int XX_W = 47;
  localparam int X_W  = 33;
  localparam int N_W  = 17;
  localparam int XY_W = 48;
  localparam int FRAC = 16;
  localparam int STALL_LIMIT = 20000;

  typedef logic signed [255:0] acc_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               last;
    logic               hold;   // wait for every outstanding result before sending
  } sample_t;

  typedef struct {
    logic signed [31:0] slope;
    logic signed [31:0] offset;
    logic               updated;
    logic               singular;
  } line_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [1:0]  m_tuser;

  incremental_line_fit u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sample_t pending[$];
  line_t   line_due[$];
  int      errors = 0;
  int      batches = 0, n_singular = 0, n_updated = 0, n_saturated = 0;

  // fit state
  acc_t tot_xx, tot_x, tot_n, bat_xx, bat_x, bat_n, bat_xy, bat_y;
  logic signed [31:0] cur_slope, cur_offset;

  function automatic acc_t wrap_u(acc_t v, int w);
    logic [255:0] u;
    u = v << (256 - w);
    return acc_t'(u >> (256 - w));
  endfunction

  function automatic acc_t wrap_s(acc_t v, int w);
    acc_t t;
    t = v << (256 - w);
    return t >>> (256 - w);
  endfunction

  // nearest, ties away from zero
  function automatic acc_t round_div(acc_t n, acc_t d);
    logic         neg;
    logic [255:0] an, ad, q;
    neg = n[255] ^ d[255];
    an = n[255] ? -n : n;
    ad = d[255] ? -d : d;
    q = ((an << 1) + ad) / (ad << 1);
    return neg ? -acc_t'(q) : acc_t'(q);
  endfunction

  function automatic logic signed [31:0] clamp_line(acc_t v);
    acc_t lo, hi;
    lo = ilf_pkg::LINE_MIN;
    hi = ilf_pkg::LINE_MAX;
    if (v < lo) return ilf_pkg::LINE_MIN;
    if (v > hi) return ilf_pkg::LINE_MAX;
    return v[31:0];
  endfunction

  function automatic void fit_reset();
    {tot_xx, tot_x, tot_n, bat_xx, bat_x, bat_n, bat_xy, bat_y} = '0;
    cur_slope = '0;
    cur_offset = '0;
  endfunction

  function automatic line_t fit_sample(sample_t s);
    line_t r;
    acc_t xs, ys, sl, of, rhs0, rhs1, det, n0, n1, ns, no;
    xs = s.x;
    ys = s.y;
    r.updated = 1'b0;
    r.singular = 1'b0;
    bat_xx = wrap_u(bat_xx + xs * xs, XX_W);
    bat_x  = wrap_s(bat_x + xs, X_W);
    bat_n  = wrap_u(bat_n + 1, N_W);
    bat_xy = wrap_s(bat_xy + xs * ys, XY_W);
    bat_y  = wrap_s(bat_y + ys, X_W);
    if (s.last) begin
      batches++;
      sl = cur_slope;
      of = cur_offset;
      tot_xx = wrap_u(tot_xx + bat_xx, XX_W);
      tot_x  = wrap_s(tot_x + bat_x, X_W);
      tot_n  = wrap_u(tot_n + bat_n, N_W);
      rhs0 = (bat_xy << FRAC) - (bat_xx * sl + bat_x * of);
      rhs1 = (bat_y << FRAC) - (bat_x * sl + bat_n * of);
      det = tot_xx * tot_n - tot_x * tot_x;
      if (det == 0) begin
        r.singular = 1'b1;
        n_singular++;
      end else begin
        n0 = tot_n * rhs0 - tot_x * rhs1;
        n1 = tot_xx * rhs1 - tot_x * rhs0;
        ns = sl + round_div(n0, det);
        no = of + round_div(n1, det);
        cur_slope = clamp_line(ns);
        cur_offset = clamp_line(no);
        if (cur_slope != ns[31:0] || cur_offset != no[31:0] || ns != acc_t'(cur_slope)
            || no != acc_t'(cur_offset))
          n_saturated++;
        r.updated = 1'b1;
        n_updated++;
      end
      {bat_xx, bat_x, bat_n, bat_xy, bat_y} = '0;
    end
    r.slope = cur_slope;
    r.offset = cur_offset;
    return r;
  endfunction

  // request driver: bursts with gaps
  int burst_left = 4, gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        line_due.push_back(fit_sample('{$signed(s_tdata[15:0]), $signed(s_tdata[31:16]),
                                        s_tlast, 1'b0}));
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending.size() > 0 && !(pending[0].hold && line_due.size() > 0)) begin
          s_tvalid <= 1'b1;
          s_tdata <= {pending[0].y, pending[0].x};
          s_tlast <= pending[0].last;
          void'(pending.pop_front());
          if (--burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor; ready follows its own stall pattern
  int stall_phase = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      stall_phase++;
      if (stall_phase % 4000 < 1500)
        m_tready <= 1'b1;
      else
        m_tready <= (stall_phase % 7 != 0) && (stall_phase % 29 > 3);
      if (m_tvalid && m_tready) begin
        if (line_due.size() == 0) begin
          $error("unexpected result slope=%0d offset=%0d", $signed(m_tdata[31:0]),
                 $signed(m_tdata[63:32]));
          errors++;
        end else begin
          line_t e;
          e = line_due.pop_front();
          if ($signed(m_tdata[31:0]) !== e.slope) begin
            $error("slope: expected %0d, got %0d", e.slope, $signed(m_tdata[31:0]));
            errors++;
          end
          if ($signed(m_tdata[63:32]) !== e.offset) begin
            $error("offset: expected %0d, got %0d", e.offset, $signed(m_tdata[63:32]));
            errors++;
          end
          if (m_tuser[0] !== e.updated) begin
            $error("updated: expected %0b, got %0b", e.updated, m_tuser[0]);
            errors++;
          end
          if (m_tuser[1] !== e.singular) begin
            $error("singular: expected %0b, got %0b", e.singular, m_tuser[1]);
            errors++;
          end
        end
      end
    end
  end

  // watchdog: cycles without any handshake
  int quiet = 0;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet <= 0;
    else if (!rst && (pending.size() > 0 || s_tvalid || line_due.size() > 0)) begin
      quiet <= quiet + 1;
      if (quiet >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic add(input int x, input int y, input bit last, input bit hold = 0);
    pending.push_back('{16'(x), 16'(y), last, hold});
  endtask

  initial begin
    int count, len, mode, wide;
    fit_reset();
    // single-sample batch: determinant zero
    add(5, 7, 1);
    // extremes
    add(-32768, 32767, 0);
    add(32767, -32768, 1);
    add(0, 0, 0);
    add(-1, -1, 0);
    add(1, 1, 1);
    // steep line forces slope saturation
    add(0, 32767, 0, 1);
    add(1, -32768, 1);
    add(0, -32768, 0);
    add(1, 32767, 1);
    add(-32768, -32768, 0);
    add(-32768, -32768, 1);
    add(32767, 32767, 0);
    add(32767, 32767, 0);
    add(-12345, 2345, 1);
    add(100, -100, 0);
    add(200, -300, 1, 1);
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    count = 17;
    while (count < 1200) begin
      mode = $urandom_range(0, 9);
      len = (mode == 0) ? 1 : (mode == 9) ? $urandom_range(20, 60) : $urandom_range(2, 8);
      wide = $urandom_range(0, 2);
      for (int i = 0; i < len; i++) begin
        int x, y;
        x = wide != 0 ? $urandom_range(0, 65535) - 32768 : $urandom_range(0, 40) - 20;
        y = wide == 2 ? $urandom_range(0, 65535) - 32768
                      : 3 * x + $urandom_range(0, 10) - 5;
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
        add(x, y, i == len - 1, (i == 0) && ($urandom_range(0, 60) == 0));
      end
      count += len;
    end

    wait (pending.size() == 0 && !s_tvalid);
    while (line_due.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("%0d samples in %0d batches: %0d solved, %0d singular, %0d saturated",
             count, batches, n_updated, n_singular, n_saturated);
    if (errors == 0 && line_due.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
rtl/ilf_pkg.sv
rtl/ilf_front.sv
rtl/ilf_mul.sv
rtl/ilf_div.sv
rtl/ilf_back.sv
rtl/incremental_line_fit.sv
rtl/ilf_checker.sv
tb/sv/tb_incremental_line_fit.sv
